// File: hdl/cht_pkg.sv
// Package for the chained hash table: sizes, codes and request/result types.
`default_nettype none

package cht_pkg;

    // Bucket count is a power of two so the hash is the low key bits.
    localparam int BUCKET_W = 4;
    localparam int BUCKETS  = 2 ** BUCKET_W;
    localparam int NODES    = 64;
    localparam int NODE_W   = $clog2(NODES);
    localparam int COUNT_W  = $clog2(NODES + 1);

    localparam int KEY_W    = 37;
    localparam int REF_W    = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_POOL_FULL = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              command;
        logic [KEY_W-1:0]  key_value;
        logic [REF_W-1:0]  record_ref;
    } request_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [REF_W-1:0]  found_ref;
    } result_t;

    // One pool node: key, record reference and the link to the next node.
    typedef struct packed {
        logic [KEY_W-1:0]  key_value;
        logic [REF_W-1:0]  record_ref;
        logic              link_valid;
        logic [NODE_W-1:0] link;
    } node_row_t;

    // One bucket: first and last node of its chain.
    typedef struct packed {
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
    } bucket_row_t;

endpackage

`default_nettype wire

// File: hdl/cht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/chained_hash_table_unit.sv
// Top level of the chained hash table: bucket and node memories and the access sequencer.
// A pool-full insert goes straight to DONE; an insert reads the bucket, writes the node and,
// for a non-empty bucket, rewrites the old tail; a lookup reads the bucket and walks its chain.
// One request at a time; each chain step is one read of the node memory,
// whose registered read port sets the pace of the walk.
// Reset clears the bucket valid bits, the pool fill count and all control state;
// the memories themselves are not cleared and need no clearing pass.
`default_nettype none

module chained_hash_table_unit
    import cht_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     request_valid,
    output logic          request_stall,
    input  wire request_t request,
    output logic          result_valid,
    input  wire logic     result_stall,
    output result_t       result
);

    // The sequencer. A request is taken only in IDLE; the finished result waits in
    // DONE until the output register is free, so a new request can enter while an
    // earlier result is still held by a stalled consumer.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_BUCKET = 5'b00010,
        S_TAIL   = 5'b00100,
        S_WALK   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [BUCKETS-1:0]  bvalid_reg, bvalid_next;
    logic [COUNT_W-1:0]  used_reg, used_next;
    request_t            req_reg, req_next;
    logic [NODE_W-1:0]   new_node_reg, new_node_next;
    bucket_row_t         brow_reg, brow_next;
    logic [1:0]          status_reg, status_next;
    logic [REF_W-1:0]    ref_reg, ref_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    // Memory ports.
    logic                bkt_wr_en;
    logic [BUCKET_W-1:0] bkt_wr_addr;
    bucket_row_t         bkt_wr_data;
    logic                bkt_rd_en;
    logic [BUCKET_W-1:0] bkt_rd_addr;
    bucket_row_t         bkt_rd_data;

    logic                node_wr_en;
    logic [NODE_W-1:0]   node_wr_addr;
    node_row_t           node_wr_data;
    logic                node_rd_en;
    logic [NODE_W-1:0]   node_rd_addr;
    node_row_t           node_rd_data;

    logic [BUCKET_W-1:0] bucket_idx;
    logic                accept;

    // The hash is the key modulo the bucket count, i.e. its low bits.
    assign bucket_idx    = req_reg.key_value[BUCKET_W-1:0];
    assign request_stall = (state_reg != S_IDLE);
    assign accept        = request_valid && !request_stall;

    cht_ram #(
        .WIDTH ($bits(bucket_row_t)),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .clk     (clk),
        .wr_en   (bkt_wr_en),
        .wr_addr (bkt_wr_addr),
        .wr_data (bkt_wr_data),
        .rd_en   (bkt_rd_en),
        .rd_addr (bkt_rd_addr),
        .rd_data (bkt_rd_data)
    );

    cht_ram #(
        .WIDTH ($bits(node_row_t)),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (node_wr_data),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        bvalid_next    = bvalid_reg;
        used_next      = used_reg;
        req_next       = req_reg;
        new_node_next  = new_node_reg;
        brow_next      = brow_reg;
        status_next    = status_reg;
        ref_next       = ref_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        bkt_wr_en      = 1'b0;
        bkt_wr_addr    = bucket_idx;
        bkt_wr_data    = brow_reg;
        bkt_rd_en      = 1'b0;
        bkt_rd_addr    = request.key_value[BUCKET_W-1:0];

        node_wr_en     = 1'b0;
        node_wr_addr   = new_node_reg;
        node_wr_data   = node_rd_data;
        node_rd_en     = 1'b0;
        node_rd_addr   = bkt_rd_data.head;

        // A delivered result frees the output register.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next      = request;
                    new_node_next = used_reg[NODE_W-1:0];
                    ref_next      = '0;
                    if (request.command == CMD_INSERT && used_reg == COUNT_W'(NODES))
                    begin
                        // The pool is exhausted: nothing changes.
                        status_next = ST_POOL_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        bkt_rd_en  = 1'b1;
                        state_next = S_BUCKET;
                    end
                end
            end

            S_BUCKET:
            begin
                brow_next = bkt_rd_data;
                if (req_reg.command == CMD_INSERT)
                begin
                    // Write the new node as the end of its chain.
                    node_wr_en              = 1'b1;
                    node_wr_addr            = new_node_reg;
                    node_wr_data.key_value  = req_reg.key_value;
                    node_wr_data.record_ref = req_reg.record_ref;
                    node_wr_data.link_valid = 1'b0;
                    node_wr_data.link       = '0;
                    used_next               = used_reg + COUNT_W'(1);
                    if (!bvalid_reg[bucket_idx])
                    begin
                        bkt_wr_en               = 1'b1;
                        bkt_wr_data.head        = new_node_reg;
                        bkt_wr_data.tail        = new_node_reg;
                        bvalid_next[bucket_idx] = 1'b1;
                        status_next             = ST_INSERTED;
                        state_next              = S_DONE;
                    end
                    else
                    begin
                        // Fetch the old tail so its link can be rewritten.
                        node_rd_en   = 1'b1;
                        node_rd_addr = bkt_rd_data.tail;
                        state_next   = S_TAIL;
                    end
                end
                else if (!bvalid_reg[bucket_idx])
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = bkt_rd_data.head;
                    state_next   = S_WALK;
                end
            end

            S_TAIL:
            begin
                // Read-modify-write of the old tail; the bucket's tail moves to the new node at the same time.
                node_wr_en              = 1'b1;
                node_wr_addr            = brow_reg.tail;
                node_wr_data            = node_rd_data;
                node_wr_data.link_valid = 1'b1;
                node_wr_data.link       = new_node_reg;
                bkt_wr_en               = 1'b1;
                bkt_wr_data.head        = brow_reg.head;
                bkt_wr_data.tail        = new_node_reg;
                status_next             = ST_INSERTED;
                state_next              = S_DONE;
            end

            S_WALK:
            begin
                if (node_rd_data.key_value == req_reg.key_value)
                begin
                    status_next = ST_FOUND;
                    ref_next    = node_rd_data.record_ref;
                    state_next  = S_DONE;
                end
                else if (node_rd_data.link_valid)
                begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = node_rd_data.link;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next     = 1'b1;
                    out_next.status    = status_reg;
                    out_next.found_ref = ref_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bvalid_reg    <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bvalid_reg    <= bvalid_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        new_node_reg <= new_node_next;
        brow_reg     <= brow_next;
        status_reg   <= status_next;
        ref_reg      <= ref_next;
        out_reg      <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
